[hw/rtl/hbs_pkg.sv]
// Shared types, constants and helpers for the height-map bilinear sampler.
`default_nettype none

package hbs_pkg;

    // Default sizes handed to the top level
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_FRAC_BITS  = 8;

    // Fixed port widths
    localparam int OUT_W   = 26;
    localparam int CFG_IW  = 2;
    localparam int CFG_DW  = 24;
    localparam int POS_W   = 24;
    localparam int SIZE_W  = 9;
    localparam int CELL_W  = 7;
    localparam int COORD_W = 8;
    localparam int BYTE_W  = 8;
    localparam int SUM_W   = 10;

    // Reciprocal of 9 with 16 fraction bits; exact for sums up to 765
    localparam int DIV9_SHIFT = 16;
    localparam int DIV9_RECIP = 7282;

    typedef enum logic [CFG_IW-1:0] {
        CFG_GRID_WIDTH  = 2'd0,
        CFG_GRID_HEIGHT = 2'd1,
        CFG_ORIGIN_X    = 2'd2,
        CFG_ORIGIN_Y    = 2'd3
    } hbs_cfg_idx_t;

    typedef enum logic [1:0] {
        ASEL_CELL = 2'd0,
        ASEL_TOP  = 2'd1,
        ASEL_ACC  = 2'd2
    } hbs_asel_t;

    typedef enum logic [1:0] {
        BSEL_W0X = 2'd0,
        BSEL_FX  = 2'd1,
        BSEL_W0Y = 2'd2,
        BSEL_FY  = 2'd3
    } hbs_bsel_t;

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2
    } hbs_accop_t;

    typedef struct packed {
        logic       capture;
        logic       do_load;
        logic       do_pos;
        logic       rd_en;
        logic [1:0] rd_k;
        logic       mul_en;
        hbs_asel_t  asel;
        hbs_bsel_t  bsel;
        hbs_accop_t acc_op;
        logic       top_save;
        logic       out_load;
    } hbs_cmd_t;

    function automatic logic [CELL_W-1:0] div9(input logic [SUM_W-1:0] s);
        logic [SUM_W+13-1:0] p;
        p = (SUM_W+13)'(s) * (SUM_W+13)'(DIV9_RECIP);
        return p[DIV9_SHIFT +: CELL_W];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/hbs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hw/rtl/hbs_ctrl.sv]
// Sequencing state machine for loads and bilinear queries.
`default_nettype none

module hbs_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              mode,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output hbs_pkg::hbs_cmd_t      cmd
);

    import hbs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_POS,
        S_RD0,
        S_RD1,
        S_RD2,
        S_RD3,
        S_MB,
        S_SUM,
        S_MY,
        S_FIN,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        cmd          = '0;
        cmd.asel     = ASEL_CELL;
        cmd.bsel     = BSEL_W0X;
        cmd.acc_op   = ACC_HOLD;
        state_next   = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = mode ? S_POS : S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.do_load = 1'b1;
                state_next  = S_IDLE;
            end
            S_POS:
            begin
                cmd.do_pos = 1'b1;
                state_next = S_RD0;
            end
            S_RD0:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_k   = 2'd0;
                state_next = S_RD1;
            end
            S_RD1:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_k   = 2'd1;
                cmd.mul_en = 1'b1;
                cmd.asel   = ASEL_CELL;
                cmd.bsel   = BSEL_W0X;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_k   = 2'd2;
                cmd.mul_en = 1'b1;
                cmd.asel   = ASEL_CELL;
                cmd.bsel   = BSEL_FX;
                cmd.acc_op = ACC_LOAD;
                state_next = S_RD3;
            end
            S_RD3:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_k   = 2'd3;
                cmd.mul_en = 1'b1;
                cmd.asel   = ASEL_CELL;
                cmd.bsel   = BSEL_W0X;
                cmd.acc_op = ACC_ADD;
                state_next = S_MB;
            end
            S_MB:
            begin
                // accumulator holds the top row blend here
                cmd.mul_en   = 1'b1;
                cmd.asel     = ASEL_CELL;
                cmd.bsel     = BSEL_FX;
                cmd.top_save = 1'b1;
                cmd.acc_op   = ACC_LOAD;
                state_next   = S_SUM;
            end
            S_SUM:
            begin
                cmd.mul_en = 1'b1;
                cmd.asel   = ASEL_TOP;
                cmd.bsel   = BSEL_W0Y;
                cmd.acc_op = ACC_ADD;
                state_next = S_MY;
            end
            S_MY:
            begin
                cmd.mul_en = 1'b1;
                cmd.asel   = ASEL_ACC;
                cmd.bsel   = BSEL_FY;
                cmd.acc_op = ACC_LOAD;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.acc_op = ACC_ADD;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[hw/rtl/hbs_datapath.sv]
// Datapath: configuration, height store, cell addressing, shared multiplier.
`default_nettype none

module hbs_datapath #(
    parameter int MAX_WIDTH  = hbs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = hbs_pkg::DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = hbs_pkg::DEF_FRAC_BITS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [hbs_pkg::CFG_IW-1:0]          cfg_index,
    input  wire logic [hbs_pkg::CFG_DW-1:0]          cfg_data,
    input  wire logic [hbs_pkg::COORD_W-1:0]         col,
    input  wire logic [hbs_pkg::COORD_W-1:0]         row,
    input  wire logic [hbs_pkg::BYTE_W-1:0]          red,
    input  wire logic [hbs_pkg::BYTE_W-1:0]          green,
    input  wire logic [hbs_pkg::BYTE_W-1:0]          blue,
    input  wire logic signed [hbs_pkg::POS_W-1:0]    query_x,
    input  wire logic signed [hbs_pkg::POS_W-1:0]    query_y,
    input  wire hbs_pkg::hbs_cmd_t                   cmd,
    output logic signed [hbs_pkg::OUT_W-1:0]         height_value
);

    import hbs_pkg::*;

    localparam int F     = FRAC_BITS;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int ADW   = CW + RW;
    localparam int DEPTH = 1 << ADW;
    localparam int XW    = (((F + SIZE_W) > (POS_W + 1)) ? (F + SIZE_W) : (POS_W + 1)) + 1;
    localparam int IW0   = XW - F + 1;
    localparam int IW1   = (IW0 > CW + 1) ? IW0 : CW + 1;
    localparam int IW2   = (IW1 > RW + 1) ? IW1 : RW + 1;
    localparam int IW    = (IW2 > SIZE_W + 1) ? IW2 : SIZE_W + 1;
    localparam int BW    = F + 2;
    localparam int AW    = F + 11;
    localparam int PW    = AW + BW;
    localparam int VW    = 2 * F + 14;
    localparam int SW    = (VW > OUT_W) ? VW : OUT_W;

    localparam logic [SIZE_W-1:0] CAP_W = (MAX_WIDTH > 511) ? 9'd511 : SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] CAP_H = (MAX_HEIGHT > 511) ? 9'd511 : SIZE_W'(MAX_HEIGHT);
    localparam logic signed [BW-1:0] ONE_B  = BW'(1 << F);
    localparam logic signed [SW-1:0] SAT_HI = SW'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [SW-1:0] SAT_LO = SW'(-(1 << (OUT_W - 1)));

    // configuration
    logic [SIZE_W-1:0]       gw_reg;
    logic [SIZE_W-1:0]       gh_reg;
    logic signed [POS_W-1:0] ox_reg;
    logic signed [POS_W-1:0] oy_reg;
    logic [SIZE_W-1:0]       eff_w;
    logic [SIZE_W-1:0]       eff_h;

    // captured transaction
    logic [COORD_W-1:0]      col_reg;
    logic [COORD_W-1:0]      row_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic signed [POS_W-1:0] qx_reg;
    logic signed [POS_W-1:0] qy_reg;

    // cell position and fraction
    logic signed [XW-1:0]    half_w;
    logic signed [XW-1:0]    half_h;
    logic signed [XW-1:0]    x_pos;
    logic signed [XW-1:0]    y_pos;
    logic signed [XW-1:0]    x_sh;
    logic signed [XW-1:0]    y_sh;
    logic                    x_adj;
    logic                    y_adj;
    logic signed [IW-1:0]    ix_reg;
    logic signed [IW-1:0]    iy_reg;
    logic signed [F:0]       fx_reg;
    logic signed [F:0]       fy_reg;

    // neighbor read
    logic [IW-1:0]           cx;
    logic [IW-1:0]           cy;
    logic                    nb_ok;
    logic                    ok_reg;
    logic [ADW-1:0]          raddr;
    logic [CELL_W-1:0]       rdata;
    logic [CELL_W-1:0]       cell_val;

    // load write
    logic                    we;
    logic [ADW-1:0]          waddr;
    logic [CELL_W-1:0]       wdata;

    // multiply and accumulate
    logic signed [BW-1:0]    w0x;
    logic signed [BW-1:0]    w0y;
    logic signed [AW-1:0]    mul_a;
    logic signed [BW-1:0]    mul_b;
    logic signed [PW-1:0]    prod_reg;
    logic signed [VW-1:0]    acc_reg;
    logic signed [AW-1:0]    top_reg;
    logic signed [SW-1:0]    v_ext;
    logic signed [SW-1:0]    v_sat;
    logic signed [OUT_W-1:0] hv_reg;

    assign eff_w = (gw_reg > CAP_W) ? CAP_W : gw_reg;
    assign eff_h = (gh_reg > CAP_H) ? CAP_H : gh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg <= SIZE_W'(256);
            gh_reg <= SIZE_W'(256);
            ox_reg <= '0;
            oy_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (hbs_cfg_idx_t'(cfg_index))
                CFG_GRID_WIDTH:  gw_reg <= cfg_data[SIZE_W-1:0];
                CFG_GRID_HEIGHT: gh_reg <= cfg_data[SIZE_W-1:0];
                CFG_ORIGIN_X:    ox_reg <= $signed(cfg_data[POS_W-1:0]);
                CFG_ORIGIN_Y:    oy_reg <= $signed(cfg_data[POS_W-1:0]);
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            col_reg <= col;
            row_reg <= row;
            sum_reg <= SUM_W'(red) + SUM_W'(green) + SUM_W'(blue);
            qx_reg  <= query_x;
            qy_reg  <= query_y;
        end
    end

    // Shift by the grid center and truncate toward zero
    assign half_w = XW'($signed({1'b0, eff_w, {(F-1){1'b0}}}));
    assign half_h = XW'($signed({1'b0, eff_h, {(F-1){1'b0}}}));
    assign x_pos  = XW'(qx_reg) - XW'(ox_reg) + half_w;
    assign y_pos  = XW'(qy_reg) - XW'(oy_reg) + half_h;
    assign x_sh   = x_pos >>> F;
    assign y_sh   = y_pos >>> F;
    assign x_adj  = x_pos[XW-1] && (x_pos[F-1:0] != '0);
    assign y_adj  = y_pos[XW-1] && (y_pos[F-1:0] != '0);

    always_ff @(posedge clk)
    begin
        if (cmd.do_pos)
        begin
            ix_reg <= IW'(x_sh) + IW'(x_adj);
            iy_reg <= IW'(y_sh) + IW'(y_adj);
            // a negative remainder is frac - 1.0, which is the frac bits under a set sign
            fx_reg <= $signed({x_adj, x_pos[F-1:0]});
            fy_reg <= $signed({y_adj, y_pos[F-1:0]});
        end
    end

    assign cx    = ix_reg + IW'(cmd.rd_k[0]);
    assign cy    = iy_reg + IW'(cmd.rd_k[1]);
    assign nb_ok = !cx[IW-1] && (cx < IW'(eff_w)) && !cy[IW-1] && (cy < IW'(eff_h));
    assign raddr = {cy[RW-1:0], cx[CW-1:0]};

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            ok_reg <= nb_ok;
        end
    end

    assign cell_val = ok_reg ? rdata : '0;

    assign we    = cmd.do_load && ({1'b0, col_reg} < eff_w) && ({1'b0, row_reg} < eff_h);
    assign waddr = {RW'(row_reg), CW'(col_reg)};
    assign wdata = div9(sum_reg);

    hbs_ram #(
        .WIDTH(CELL_W),
        .DEPTH(DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (cmd.rd_en),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign w0x = ONE_B - BW'(fx_reg);
    assign w0y = ONE_B - BW'(fy_reg);

    always_comb
    begin
        case (cmd.asel)
            ASEL_CELL: mul_a = $signed(AW'(cell_val));
            ASEL_TOP:  mul_a = top_reg;
            ASEL_ACC:  mul_a = AW'(acc_reg);
            default:   mul_a = '0;
        endcase
        case (cmd.bsel)
            BSEL_W0X: mul_b = w0x;
            BSEL_FX:  mul_b = BW'(fx_reg);
            BSEL_W0Y: mul_b = w0y;
            BSEL_FY:  mul_b = BW'(fy_reg);
            default:  mul_b = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= PW'(mul_a) * PW'(mul_b);
        end
        case (cmd.acc_op)
            ACC_LOAD: acc_reg <= VW'(prod_reg);
            ACC_ADD:  acc_reg <= acc_reg + VW'(prod_reg);
            default:  ;
        endcase
        if (cmd.top_save)
        begin
            top_reg <= AW'(acc_reg);
        end
    end

    // Saturate to the output range
    assign v_ext = SW'(acc_reg);

    always_comb
    begin
        if (v_ext > SAT_HI)
        begin
            v_sat = SAT_HI;
        end
        else if (v_ext < SAT_LO)
        begin
            v_sat = SAT_LO;
        end
        else
        begin
            v_sat = v_ext;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            hv_reg <= OUT_W'(v_sat);
        end
    end

    assign height_value = hv_reg;

endmodule

`default_nettype wire

[hw/rtl/heightmap_bilinear_sampler.sv]
// Top level of the height-map bilinear sampler.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_stall  | mode, col, row, red, green, blue, query_x, query_y
//  out     | out_valid / out_stall| height_value
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  A load transaction is a capture, then one write to the height store.
//  A query transaction runs through position, four store reads through the single
//  read port, six products through one shared multiplier, then the output register.
//  The output register frees the controller; a query only waits in its last step when
//  the previous result is still stalled. cfg_ready is always high. Reset clears
//  control state and origin, sets a 256 x 256 grid; the height store is not cleared.
`default_nettype none

module heightmap_bilinear_sampler #(
    parameter int MAX_WIDTH  = hbs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = hbs_pkg::DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = hbs_pkg::DEF_FRAC_BITS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                mode,
    input  wire logic [hbs_pkg::COORD_W-1:0]         col,
    input  wire logic [hbs_pkg::COORD_W-1:0]         row,
    input  wire logic [hbs_pkg::BYTE_W-1:0]          red,
    input  wire logic [hbs_pkg::BYTE_W-1:0]          green,
    input  wire logic [hbs_pkg::BYTE_W-1:0]          blue,
    input  wire logic signed [hbs_pkg::POS_W-1:0]    query_x,
    input  wire logic signed [hbs_pkg::POS_W-1:0]    query_y,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [hbs_pkg::OUT_W-1:0]         height_value,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [hbs_pkg::CFG_IW-1:0]          cfg_index,
    input  wire logic [hbs_pkg::CFG_DW-1:0]          cfg_data
);

    import hbs_pkg::*;

    hbs_cmd_t cmd;
    logic     cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    hbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode),
        .in_stall (in_stall),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .cmd      (cmd)
    );

    hbs_datapath #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .col         (col),
        .row         (row),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .query_x     (query_x),
        .query_y     (query_y),
        .cmd         (cmd),
        .height_value(height_value)
    );

endmodule

`default_nettype wire

[hw/rtl/hbs_checker.sv]
// Port-level assertions for the sampler, bound to the top level.
`default_nettype none

module hbs_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_stall,
    input wire logic                        mode,
    input wire logic                        out_valid,
    input wire logic                        out_stall,
    input wire logic [hbs_pkg::OUT_W-1:0]   height_value
);

    // the block goes busy right after taking a transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after an accepted transaction");

    // a query's result never rises straight after the query is taken
    a_query_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && mode) |=> !$rose(out_valid))
        else $error("result appeared one cycle after a query");

    // a load produces no result
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !mode) |=> !$rose(out_valid) ##1 !$rose(out_valid))
        else $error("result appeared after a load");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(height_value)))
        else $error("stalled result changed or dropped");

endmodule

bind heightmap_bilinear_sampler hbs_checker u_hbs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .height_value(height_value)
);

`default_nettype wire

[tb/hbs_tb_pkg.sv]
`timescale 1ns / 100ps
// Item mode codes shared by the sampler testbench and its checker.
package hbs_tb_pkg;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

endpackage

[tb/hbs_height_checker.sv]
`timescale 1ns / 100ps
// Checker for the height-map sampler: mirrors the height grid and compares each result.
module hbs_height_checker
    import hbs_pkg::*;
    import hbs_tb_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire logic                     in_stall,
    input  wire logic                     mode,
    input  wire logic [COORD_W-1:0]       col,
    input  wire logic [COORD_W-1:0]       row,
    input  wire logic [BYTE_W-1:0]        red,
    input  wire logic [BYTE_W-1:0]        green,
    input  wire logic [BYTE_W-1:0]        blue,
    input  wire logic signed [POS_W-1:0]  query_x,
    input  wire logic signed [POS_W-1:0]  query_y,
    input  wire logic                     out_valid,
    input  wire logic                     out_stall,
    input  wire logic signed [OUT_W-1:0]  height_value,
    input  wire logic                     cfg_valid,
    input  wire logic                     cfg_ready,
    input  wire logic [CFG_IW-1:0]        cfg_index,
    input  wire logic [CFG_DW-1:0]        cfg_data,
    output int                            fail_count,
    output int                            waiting
);

    localparam longint ONE     = longint'(1) << DEF_FRAC_BITS;
    localparam longint OUT_MIN = -(longint'(1) << (OUT_W - 1));
    localparam longint OUT_MAX = (longint'(1) << (OUT_W - 1)) - 1;

    logic [CELL_W-1:0]       height_mirror [0:DEF_MAX_WIDTH*DEF_MAX_HEIGHT-1];
    logic [SIZE_W-1:0]       grid_w;
    logic [SIZE_W-1:0]       grid_h;
    logic signed [POS_W-1:0] org_x;
    logic signed [POS_W-1:0] org_y;
    logic signed [OUT_W-1:0] pending_heights [$];
    logic signed [OUT_W-1:0] expected;

    initial fail_count = 0;
    initial waiting = 0;

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        fail_count++;
    endtask

    function automatic longint span_of(input logic [SIZE_W-1:0] n, input int limit);
        return (n > limit) ? longint'(limit) : longint'(n);
    endfunction

    // Cells outside the grid in use read as zero.
    function automatic longint height_at(input longint c, input longint r);
        if (c < 0 || r < 0 || c >= span_of(grid_w, DEF_MAX_WIDTH) ||
            r >= span_of(grid_h, DEF_MAX_HEIGHT))
            return 0;
        return longint'(height_mirror[r * DEF_MAX_WIDTH + c]);
    endfunction

    function automatic logic signed [OUT_W-1:0] predict_height(
        input logic signed [POS_W-1:0] qx,
        input logic signed [POS_W-1:0] qy
    );
        longint px, py, ix, iy, fx, fy, upper, lower, v;
        px = longint'(qx) - longint'(org_x) + span_of(grid_w, DEF_MAX_WIDTH) * ONE / 2;
        py = longint'(qy) - longint'(org_y) + span_of(grid_h, DEF_MAX_HEIGHT) * ONE / 2;
        // Division truncates toward zero, so fractions go negative left of zero.
        ix = px / ONE;
        iy = py / ONE;
        fx = px - ix * ONE;
        fy = py - iy * ONE;
        upper = (ONE - fx) * height_at(ix, iy) + fx * height_at(ix + 1, iy);
        lower = (ONE - fx) * height_at(ix, iy + 1) + fx * height_at(ix + 1, iy + 1);
        v = upper * (ONE - fy) + lower * fy;
        if (v < OUT_MIN)
            v = OUT_MIN;
        if (v > OUT_MAX)
            v = OUT_MAX;
        return v[OUT_W-1:0];
    endfunction

    task automatic store_pixel(input logic [COORD_W-1:0] c, input logic [COORD_W-1:0] r,
                               input logic [BYTE_W-1:0] rd, input logic [BYTE_W-1:0] gr,
                               input logic [BYTE_W-1:0] bl);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(rd) + SUM_W'(gr) + SUM_W'(bl);
        if (c < span_of(grid_w, DEF_MAX_WIDTH) && r < span_of(grid_h, DEF_MAX_HEIGHT))
            height_mirror[{r, c}] = CELL_W'(sum / 9);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_w <= SIZE_W'(DEF_MAX_WIDTH);
            grid_h <= SIZE_W'(DEF_MAX_HEIGHT);
            org_x  <= '0;
            org_y  <= '0;
            pending_heights.delete();
            waiting <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_GRID_WIDTH:  grid_w <= cfg_data[SIZE_W-1:0];
                    CFG_GRID_HEIGHT: grid_h <= cfg_data[SIZE_W-1:0];
                    CFG_ORIGIN_X:    org_x  <= cfg_data;
                    CFG_ORIGIN_Y:    org_y  <= cfg_data;
                    default: ;
                endcase
            end
            // Check the output before queuing, so a stray result never meets a fresh entry.
            if (out_valid && !out_stall)
            begin
                if (pending_heights.size() == 0)
                    report_mismatch($sformatf("height_value %0d with no query waiting",
                                              height_value));
                else
                begin
                    expected = pending_heights.pop_front();
                    if (height_value !== expected)
                        report_mismatch($sformatf("height_value %0d, expected %0d",
                                                  height_value, expected));
                end
            end
            if (in_valid && !in_stall)
            begin
                if (mode == MODE_QUERY)
                    pending_heights.push_back(predict_height(query_x, query_y));
                else
                    store_pixel(col, row, red, green, blue);
            end
            waiting <= pending_heights.size();
        end
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// Testbench top for the height-map sampler: clock, reset, stimulus and verdict.
module testbench;
    import hbs_pkg::*;
    import hbs_tb_pkg::*;

    localparam int     STALL_LIMIT   = 2000;
    localparam int     SETTLE_CYCLES = 16;
    localparam longint ONE           = longint'(1) << DEF_FRAC_BITS;
    localparam longint POS_MIN       = -(longint'(1) << (POS_W - 1));
    localparam longint POS_MAX       = (longint'(1) << (POS_W - 1)) - 1;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_stall;
    logic                    mode      = MODE_LOAD;
    logic [COORD_W-1:0]      col       = '0;
    logic [COORD_W-1:0]      row       = '0;
    logic [BYTE_W-1:0]       red       = '0;
    logic [BYTE_W-1:0]       green     = '0;
    logic [BYTE_W-1:0]       blue      = '0;
    logic signed [POS_W-1:0] query_x   = '0;
    logic signed [POS_W-1:0] query_y   = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [OUT_W-1:0] height_value;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    hbs_cfg_idx_t            cfg_index = CFG_GRID_WIDTH;
    logic [CFG_DW-1:0]       cfg_data  = '0;

    int mismatches;
    int waiting;
    int items_sent  = 0;
    int idle_cycles = 0;
    bit calm        = 1'b0;

    // Testbench view of the grid setting and of which cells hold a height.
    logic [SIZE_W-1:0]       cur_w  = SIZE_W'(DEF_MAX_WIDTH);
    logic [SIZE_W-1:0]       cur_h  = SIZE_W'(DEF_MAX_HEIGHT);
    logic signed [POS_W-1:0] cur_ox = '0;
    logic signed [POS_W-1:0] cur_oy = '0;
    bit                      written [0:DEF_MAX_WIDTH*DEF_MAX_HEIGHT-1];

    heightmap_bilinear_sampler dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .col          (col),
        .row          (row),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .query_x      (query_x),
        .query_y      (query_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .height_value (height_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    hbs_height_checker height_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .col          (col),
        .row          (row),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .query_x      (query_x),
        .query_y      (query_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .height_value (height_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (mismatches),
        .waiting      (waiting)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(99) < 12);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic longint span_of(input logic [SIZE_W-1:0] n, input int limit);
        return (n > limit) ? longint'(limit) : longint'(n);
    endfunction

    function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
        if (v < POS_MIN)
            return POS_W'(POS_MIN);
        if (v > POS_MAX)
            return POS_W'(POS_MAX);
        return POS_W'(v);
    endfunction

    // Present one item and hold it until the block takes it; valid stays high afterwards.
    task automatic push_item(input logic m, input logic [COORD_W-1:0] c,
                             input logic [COORD_W-1:0] r, input logic [BYTE_W-1:0] rd,
                             input logic [BYTE_W-1:0] gr, input logic [BYTE_W-1:0] bl,
                             input logic signed [POS_W-1:0] qx,
                             input logic signed [POS_W-1:0] qy);
        bit taken;
        if (!calm)
            while ($urandom_range(99) < 12)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid <= 1'b1;
        mode     <= m;
        col      <= c;
        row      <= r;
        red      <= rd;
        green    <= gr;
        blue     <= bl;
        query_x  <= qx;
        query_y  <= qy;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        items_sent++;
    endtask

    task automatic send_load(input int c, input int r, input logic [BYTE_W-1:0] rd,
                             input logic [BYTE_W-1:0] gr, input logic [BYTE_W-1:0] bl);
        if (c < span_of(cur_w, DEF_MAX_WIDTH) && r < span_of(cur_h, DEF_MAX_HEIGHT))
            written[r * DEF_MAX_WIDTH + c] = 1'b1;
        push_item(MODE_LOAD, COORD_W'(c), COORD_W'(r), rd, gr, bl,
                  POS_W'($urandom), POS_W'($urandom));
    endtask

    // Load any neighbour in the grid that holds no height yet, then send the query.
    task automatic send_query(input logic signed [POS_W-1:0] qx,
                              input logic signed [POS_W-1:0] qy);
        longint span_w, span_h, ix, iy, c, r;
        span_w = span_of(cur_w, DEF_MAX_WIDTH);
        span_h = span_of(cur_h, DEF_MAX_HEIGHT);
        ix = (longint'(qx) - longint'(cur_ox) + span_w * ONE / 2) / ONE;
        iy = (longint'(qy) - longint'(cur_oy) + span_h * ONE / 2) / ONE;
        for (int dy = 0; dy < 2; dy++)
            for (int dx = 0; dx < 2; dx++)
            begin
                c = ix + dx;
                r = iy + dy;
                if (c >= 0 && c < span_w && r >= 0 && r < span_h &&
                    !written[r * DEF_MAX_WIDTH + c])
                    send_load(int'(c), int'(r), BYTE_W'($urandom), BYTE_W'($urandom),
                              BYTE_W'($urandom));
            end
        push_item(MODE_QUERY, COORD_W'($urandom), COORD_W'($urandom), BYTE_W'($urandom),
                  BYTE_W'($urandom), BYTE_W'($urandom), qx, qy);
    endtask

    // Drop valid, wait for every result, then let a trailing load finish.
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (waiting != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input hbs_cfg_idx_t idx, input logic [CFG_DW-1:0] data);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    task automatic set_grid(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                            input logic signed [POS_W-1:0] ox,
                            input logic signed [POS_W-1:0] oy);
        settle();
        // Upper data bits of the size registers carry noise; only the low bits count.
        write_reg(CFG_GRID_WIDTH, {(CFG_DW - SIZE_W)'($urandom), w});
        write_reg(CFG_GRID_HEIGHT, {(CFG_DW - SIZE_W)'($urandom), h});
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        cfg_valid <= 1'b0;
        cur_w  = w;
        cur_h  = h;
        cur_ox = ox;
        cur_oy = oy;
    endtask

    task automatic random_traffic(input int goal);
        int     stop;
        int     pick;
        longint span_w, span_h, tx, ty;
        stop = items_sent + goal;
        while (items_sent < stop)
        begin
            pick   = $urandom_range(99);
            span_w = span_of(cur_w, DEF_MAX_WIDTH);
            span_h = span_of(cur_h, DEF_MAX_HEIGHT);
            if (pick < 55)
            begin
                // Land within a few cells of the grid, negative side included.
                tx = longint'($urandom_range(int'((span_w + 5) * ONE))) - 3 * ONE;
                ty = longint'($urandom_range(int'((span_h + 5) * ONE))) - 3 * ONE;
                send_query(clamp_pos(tx - span_w * ONE / 2 + longint'(cur_ox)),
                           clamp_pos(ty - span_h * ONE / 2 + longint'(cur_oy)));
            end
            else if (pick < 65)
                send_query(POS_W'($urandom), POS_W'($urandom));
            else if (pick < 85 && span_w > 0 && span_h > 0)
                send_load($urandom_range(int'(span_w) - 1), $urandom_range(int'(span_h) - 1),
                          BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
            else
                send_load($urandom_range(255), $urandom_range(255), BYTE_W'($urandom),
                          BYTE_W'($urandom), BYTE_W'($urandom));
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: 256 x 256 grid centered on the origin, cell (128, 128) at zero.
        send_load(0, 0, 8'd255, 8'd255, 8'd255);
        send_load(255, 255, 8'd0, 8'd0, 8'd0);
        send_load(1, 0, 8'd0, 8'd0, 8'd0);
        send_load(0, 1, 8'd0, 8'd0, 8'd0);
        send_load(1, 1, 8'd255, 8'd255, 8'd255);
        send_load(128, 128, 8'd100, 8'd50, 8'd20);
        send_load(255, 0, 8'd255, 8'd255, 8'd254);
        send_load(0, 255, 8'd8, 8'd0, 8'd0);
        send_query(24'sd0, 24'sd0);
        send_query(24'sd128, -24'sd128);
        // Left of zero: fraction goes negative and the blend extrapolates.
        send_query(-24'sd33023, -24'sd33023);
        send_query(-24'sd32769, 24'sd0);
        send_query(-24'sd32768, -24'sd32768);
        // Far corner: the right and lower neighbours fall off the grid.
        send_query(24'sd32767, 24'sd32767);
        send_query(clamp_pos(POS_MIN), clamp_pos(POS_MIN));
        send_query(clamp_pos(POS_MAX), clamp_pos(POS_MAX));
        random_traffic(45);

        // Single cell; loads off that cell are dropped.
        set_grid(9'd1, 9'd1, 24'sd0, 24'sd0);
        send_load(1, 0, 8'd200, 8'd200, 8'd200);
        send_load(0, 1, 8'd200, 8'd200, 8'd200);
        send_load(255, 255, 8'd255, 8'd255, 8'd255);
        send_query(24'sd0, 24'sd0);
        random_traffic(40);

        set_grid(9'd256, 9'd256, clamp_pos(POS_MAX), clamp_pos(POS_MIN));
        random_traffic(45);

        // Zero width leaves no cell in use; oversize height clips to the maximum.
        set_grid(9'd0, 9'd300, POS_W'($urandom), POS_W'($urandom));
        random_traffic(30);

        set_grid(9'd511, 9'd1, clamp_pos(longint'($urandom_range(8192)) - 4096),
                 clamp_pos(longint'($urandom_range(8192)) - 4096));
        random_traffic(40);

        // Back-to-back stretch: neither side idles.
        calm <= 1'b1;
        set_grid(SIZE_W'($urandom_range(1, 256)), SIZE_W'($urandom_range(1, 256)),
                 clamp_pos(longint'($urandom_range(131072)) - 65536),
                 clamp_pos(longint'($urandom_range(131072)) - 65536));
        random_traffic(70);
        settle();
        calm <= 1'b0;

        set_grid(9'd2, 9'd256, clamp_pos(POS_MIN), clamp_pos(POS_MAX));
        random_traffic(45);

        set_grid(SIZE_W'($urandom_range(1, 16)), SIZE_W'($urandom_range(1, 16)),
                 clamp_pos(longint'($urandom_range(8192)) - 4096),
                 clamp_pos(longint'($urandom_range(8192)) - 4096));
        random_traffic(60);

        settle();
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
